// ===== rtl/rpy_pkg.sv =====
package rpy_pkg;

    localparam int Stages = 16;
    localparam int VecW   = 30;
    localparam int AngW   = 28;
    localparam int StW    = $clog2(Stages + 1);

    localparam logic signed [AngW-1:0] AngPi = 28'sd52707179;
    localparam logic signed [31:0] KinvQ30 = 32'sd652032874;
    localparam int OutLimit = 25736;

    typedef logic signed [VecW-1:0] t_vec;
    typedef logic signed [AngW-1:0] t_ang;

    // One vector pair (x and y)
    typedef struct packed {
        t_vec x;
        t_vec y;
    } t_pair;

    function automatic t_ang atan_lut(input int i);
        case (i)
            0: atan_lut = 28'sd13176795;
            1: atan_lut = 28'sd7778716;
            2: atan_lut = 28'sd4110060;
            3: atan_lut = 28'sd2086331;
            4: atan_lut = 28'sd1047214;
            5: atan_lut = 28'sd524117;
            6: atan_lut = 28'sd262123;
            7: atan_lut = 28'sd131069;
            8: atan_lut = 28'sd65536;
            9: atan_lut = 28'sd32768;
            10: atan_lut = 28'sd16384;
            11: atan_lut = 28'sd8192;
            12: atan_lut = 28'sd4096;
            13: atan_lut = 28'sd2048;
            14: atan_lut = 28'sd1024;
            15: atan_lut = 28'sd512;
            16: atan_lut = 28'sd256;
            17: atan_lut = 28'sd128;
            18: atan_lut = 28'sd64;
            19: atan_lut = 28'sd32;
            20: atan_lut = 28'sd16;
            21: atan_lut = 28'sd8;
            22: atan_lut = 28'sd4;
            23: atan_lut = 28'sd2;
            default: atan_lut = '0;
        endcase
    endfunction

    // Round 2^-24 rad to Q3.13 and clamp
    function automatic logic signed [15:0] to_out(input t_ang z);
        logic signed [AngW:0] r;
        r = (AngW+1)'(z + t_ang'(1024)) >>> 11;
        if (r > OutLimit) begin
            to_out = 16'(OutLimit);
        end else if (r < -OutLimit) begin
            to_out = 16'(-OutLimit);
        end else begin
            to_out = r[15:0];
        end
    endfunction

endpackage

// ===== rtl/rotation_to_roll_pitch_yaw_core.sv =====
// o_valid follows start through the input beat, both CORDIC rows, the 1/K register and output beat.
// Throughput: one matrix per cycle; busy is always low, two CORDIC rows in series.
// Results show for one cycle on o_valid; the receiver cannot stall.
// Reset (synchronous, active low) clears the valid pipe and sets the threshold to 1.
module rotation_to_roll_pitch_yaw_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [14:0]        i_cfg_data,
    input  logic signed [15:0] i_r00,
    input  logic signed [15:0] i_r10,
    input  logic signed [15:0] i_r20,
    input  logic signed [15:0] i_r01,
    input  logic signed [15:0] i_r11,
    input  logic signed [15:0] i_r02,
    input  logic signed [15:0] i_r12,
    output logic               o_valid,
    output logic signed [15:0] o_roll,
    output logic signed [15:0] o_pitch,
    output logic signed [15:0] o_yaw,
    output logic               o_singular
);
    localparam int N   = rpy_pkg::Stages;
    localparam int LAT = 2 * N + 3;
    localparam int VW  = rpy_pkg::VecW;

    logic [14:0] r_thr;
    logic [LAT-1:0] r_vld;
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 15'd1;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) r_thr <= i_cfg_data;
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    function automatic rpy_pkg::t_vec sc(input logic signed [15:0] a);
        return rpy_pkg::t_vec'(a) <<< 8;
    endfunction
    function automatic logic [16:0] mag(input logic signed [16:0] a);
        return a[16] ? 17'(-a) : 17'(a);
    endfunction

    // input beat: gimbal test and first-row operands
    logic r_sing0;
    rpy_pkg::t_pair r_a0, r_a1, r_a2;
    rpy_pkg::t_vec  r_yp0, r_xs0, r_ys0, r_xs1;
    always_ff @(posedge i_clk) begin
        r_sing0 <= (mag(17'(i_r00)) < {2'b0, r_thr}) && (mag(17'(i_r10)) < {2'b0, r_thr});
        r_a0 <= '{x: sc(i_r00), y: sc(i_r10)};
        r_a1 <= '{x: sc(i_r01), y: sc(i_r11)};
        r_a2 <= '{x: sc(i_r02), y: sc(i_r12)};
        r_yp0 <= -sc(i_r20);
        r_xs0 <= sc(i_r00);
        r_ys0 <= -sc(i_r12);
        r_xs1 <= sc(i_r11);
    end

    // first row: roll with followers, or in gimbal case pitch here and yaw on the side row
    rpy_pkg::t_pair f0, f1, f2, s0, s1, s2;
    rpy_pkg::t_ang  z1;
    always_comb begin
        if (r_sing0) begin
            s0 = '{x: r_xs0, y: r_yp0};
            s1 = '{x: r_xs1, y: r_ys0};
        end else begin
            s0 = r_a0;
            s1 = r_a1;
        end
        s2 = r_a2;
    end
    // only lead vector drives the row; second gimbal atan2 rides a separate row
    rpy_chain u_row1 (.i_clk(i_clk), .i_v0(s0), .i_v1(s1), .i_v2(s2),
                      .o_v0(f0), .o_v1(f1), .o_v2(f2), .o_z(z1));
    rpy_pkg::t_pair g0, g1, g2;
    rpy_pkg::t_ang  zg;
    rpy_chain u_rowg (.i_clk(i_clk), .i_v0('{x: r_xs1, y: r_ys0}), .i_v1('0), .i_v2('0),
                      .o_v0(g0), .o_v1(g1), .o_v2(g2), .o_z(zg));

    // side delay lines for the gimbal flag and -r20
    logic           r_sd [N];
    rpy_pkg::t_vec  r_pd [N];
    always_ff @(posedge i_clk) begin
        r_sd[0] <= r_sing0;
        r_pd[0] <= r_yp0;
        for (int k = 1; k < N; k++) begin
            r_sd[k] <= r_sd[k-1];
            r_pd[k] <= r_pd[k-1];
        end
    end

    // magnitude scaled by 1/K
    logic signed [61:0] r_prod;
    rpy_pkg::t_ang  r_z1;
    rpy_pkg::t_pair r_f2, r_f1;
    rpy_pkg::t_vec  r_p2;
    rpy_pkg::t_ang  r_zg;
    logic           r_s2;
    always_ff @(posedge i_clk) begin
        r_prod <= 62'(f0.x) * 62'(rpy_pkg::KinvQ30);
        r_z1 <= z1; r_f1 <= f1; r_f2 <= f2; r_p2 <= r_pd[N-1];
        r_zg <= zg; r_s2 <= r_sd[N-1];
    end
    logic signed [61:0] msh;
    assign msh = r_prod >>> 30;

    // second row: pitch lead, yaw as lead vector of its own row
    rpy_pkg::t_pair p0, q0, unused1, unused2, unused3, unused4;
    rpy_pkg::t_ang  zp, zy;
    rpy_pkg::t_pair pin, yin;
    always_comb begin
        pin = '{x: VW'(msh), y: r_p2};
        yin = '{x: r_f1.y, y: -r_f2.y};
    end
    rpy_chain u_row2p (.i_clk(i_clk), .i_v0(pin), .i_v1('0), .i_v2('0),
                       .o_v0(p0), .o_v1(unused1), .o_v2(unused2), .o_z(zp));
    rpy_chain u_row2y (.i_clk(i_clk), .i_v0(yin), .i_v1('0), .i_v2('0),
                       .o_v0(q0), .o_v1(unused3), .o_v2(unused4), .o_z(zy));

    // delay first-row results across second row
    rpy_pkg::t_ang r_zd [N];
    rpy_pkg::t_ang r_zgd [N];
    logic          r_sgd [N];
    always_ff @(posedge i_clk) begin
        r_zd[0] <= r_z1; r_zgd[0] <= r_zg; r_sgd[0] <= r_s2;
        for (int k = 1; k < N; k++) begin
            r_zd[k] <= r_zd[k-1]; r_zgd[k] <= r_zgd[k-1]; r_sgd[k] <= r_sgd[k-1];
        end
    end

    // output beat
    always_ff @(posedge i_clk) begin
        if (r_sgd[N-1]) begin
            o_roll  <= '0;
            o_pitch <= rpy_pkg::to_out(r_zd[N-1]);
            o_yaw   <= rpy_pkg::to_out(r_zgd[N-1]);
        end else begin
            o_roll  <= rpy_pkg::to_out(r_zd[N-1]);
            o_pitch <= rpy_pkg::to_out(zp);
            o_yaw   <= rpy_pkg::to_out(zy);
        end
        o_singular <= r_sgd[N-1];
    end
    assign o_valid = r_vld[LAT-1];

    logic unused_ok;
    assign unused_ok = ^{p0, q0, g0, g1, g2, unused1, unused2, unused3, unused4, r_f1.x,
                         r_f2.x, r_f1.y};
endmodule

// ===== rtl/rpy_cell.sv =====
// One vectoring micro-rotation for a lead vector and two followers
module rpy_cell (
    input  logic          i_clk,
    input  logic [4:0]    i_shift,
    input  rpy_pkg::t_ang i_step,
    input  logic          i_zero,
    input  rpy_pkg::t_pair i_v0,
    input  rpy_pkg::t_pair i_v1,
    input  rpy_pkg::t_pair i_v2,
    input  rpy_pkg::t_ang i_z,
    output rpy_pkg::t_pair o_v0,
    output rpy_pkg::t_pair o_v1,
    output rpy_pkg::t_pair o_v2,
    output rpy_pkg::t_ang o_z,
    output logic          o_zero
);
    rpy_pkg::t_pair n_v0, n_v1, n_v2;
    rpy_pkg::t_ang  n_z;
    logic cw;

    function automatic rpy_pkg::t_pair rot(input rpy_pkg::t_pair p, input logic c,
                                           input logic [4:0] s);
        rpy_pkg::t_pair q;
        if (c) begin
            q.x = p.x + (p.y >>> s);
            q.y = p.y - (p.x >>> s);
        end else begin
            q.x = p.x - (p.y >>> s);
            q.y = p.y + (p.x >>> s);
        end
        return q;
    endfunction

    // zero lead vector: everything passes unchanged
    always_comb begin
        cw   = ~i_v0.y[rpy_pkg::VecW-1];
        n_v0 = i_v0;
        n_v1 = i_v1;
        n_v2 = i_v2;
        n_z  = i_z;
        if (!i_zero) begin
            n_v0 = rot(i_v0, cw, i_shift);
            n_v1 = rot(i_v1, cw, i_shift);
            n_v2 = rot(i_v2, cw, i_shift);
            n_z  = cw ? i_z + i_step : i_z - i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        o_v0   <= n_v0;
        o_v1   <= n_v1;
        o_v2   <= n_v2;
        o_z    <= n_z;
        o_zero <= i_zero;
    end
endmodule

// ===== rtl/rpy_chain.sv =====
// Quadrant pre-rotation followed by a row of micro-rotation cells
module rpy_chain (
    input  logic           i_clk,
    input  rpy_pkg::t_pair i_v0,
    input  rpy_pkg::t_pair i_v1,
    input  rpy_pkg::t_pair i_v2,
    output rpy_pkg::t_pair o_v0,
    output rpy_pkg::t_pair o_v1,
    output rpy_pkg::t_pair o_v2,
    output rpy_pkg::t_ang  o_z
);
    localparam int N = rpy_pkg::Stages;
    rpy_pkg::t_pair v0 [N+1];
    rpy_pkg::t_pair v1 [N+1];
    rpy_pkg::t_pair v2 [N+1];
    rpy_pkg::t_ang  z  [N+1];
    logic           zr [N+1];

    function automatic rpy_pkg::t_pair neg(input rpy_pkg::t_pair p, input logic f);
        rpy_pkg::t_pair q;
        q.x = f ? -p.x : p.x;
        q.y = f ? -p.y : p.y;
        return q;
    endfunction

    // pre-rotation by pi for a left half-plane lead vector
    always_comb begin
        logic flip;
        flip  = i_v0.x[rpy_pkg::VecW-1];
        zr[0] = (i_v0.x == '0) && (i_v0.y == '0);
        v0[0] = neg(i_v0, flip);
        v1[0] = neg(i_v1, flip);
        v2[0] = neg(i_v2, flip);
        z[0]  = !flip ? '0 : (i_v0.y[rpy_pkg::VecW-1] ? -rpy_pkg::AngPi : rpy_pkg::AngPi);
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        rpy_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(5'(g)),
            .i_step (rpy_pkg::atan_lut(g)),
            .i_zero (zr[g]),
            .i_v0   (v0[g]),
            .i_v1   (v1[g]),
            .i_v2   (v2[g]),
            .i_z    (z[g]),
            .o_v0   (v0[g+1]),
            .o_v1   (v1[g+1]),
            .o_v2   (v2[g+1]),
            .o_z    (z[g+1]),
            .o_zero (zr[g+1])
        );
    end

    assign o_v0 = v0[N];
    assign o_v1 = v1[N];
    assign o_v2 = v2[N];
    assign o_z  = zr[N] ? '0 : z[N];
endmodule

// ===== rtl/rpy_checker.sv =====
module rpy_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               o_valid,
    input logic               o_singular,
    input logic signed [15:0] o_roll,
    input logic signed [15:0] o_pitch,
    input logic signed [15:0] o_yaw
);
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_roll == 16'sd0) else $error("roll in gimbal");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch <= 16'sd25736 && o_pitch >= -16'sd25736 &&
                     o_yaw <= 16'sd25736 && o_yaw >= -16'sd25736)) else $error("range");
endmodule

bind rotation_to_roll_pitch_yaw_core rpy_checker u_chk (.*);
